/* hdl/wsh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsh_pkg: shared types and constants
// Item structs, state encoding and controller/datapath command and status.
// ----------------------------------------------------------------------------
package wsh_pkg;

  localparam int unsigned Bins       = 1000;
  localparam int unsigned CountWidth = 48;
  localparam int unsigned NumCats    = 5;
  localparam int unsigned RowLen     = Bins + 1;
  localparam int unsigned Depth      = NumCats * RowLen;
  localparam int unsigned AddrW      = $clog2(Depth);
  localparam int unsigned DistW      = 24;
  localparam int unsigned QuoW       = 10;

  localparam logic [1:0] KindAcc      = 2'd0;
  localparam logic [1:0] KindRead     = 2'd1;
  localparam logic [1:0] KindReadClr  = 2'd2;
  localparam logic [1:0] KindSpare    = 2'd3;

  localparam logic [2:0] CatGenM  = 3'd0;
  localparam logic [2:0] CatGenF  = 3'd1;
  localparam logic [2:0] CatImpM  = 3'd2;
  localparam logic [2:0] CatImpF  = 3'd3;
  localparam logic [2:0] CatCross = 3'd4;

  localparam logic [DistW-1:0] MaxDistReset = 24'd655360;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] distance;
    logic        same_identity;
    logic        row_is_male;
    logic        col_is_male;
    logic [11:0] row_weight;
    logic [11:0] col_weight;
    logic [2:0]  read_category;
    logic [9:0]  read_bin;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  category;
    logic [9:0]  bin;
    logic [47:0] bin_count;
    logic        saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    StClear, StIdle, StDivide, StAddr, StRead, StData, StWrite, StDone
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic div_step;
    logic make_addr;
    logic mem_read;
    logic update;
    logic mem_write;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic is_acc;
  } sts_t;

endpackage

/* hdl/weighted_score_histogram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_score_histogram: five weighted distance histograms
// Accumulate items run the 10-step divider, then address, read, update and write; read items skip the divide steps.
// Next item taken the cycle after the result; no new item is taken while one is in flight.
// After reset a clearing pass zeroes the store (busy high).
// Result is shown for one cycle with valid_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
module weighted_score_histogram (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  wsh_pkg::in_item_t  item_i,
  output logic               valid_o,
  output wsh_pkg::out_item_t result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [23:0]        cfg_data_i
);
  import wsh_pkg::*;

  cmd_t     cmd;
  sts_t     sts;

  assign cfg_ready_o = 1'b1;

  wsh_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (valid_o)
  );

  wsh_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (result_o)
  );

endmodule

/* hdl/wsh_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsh_datapath: quantiser, counter store and saturating update
// Restoring divider, one quotient bit a cycle; single-port counter memory.
// ----------------------------------------------------------------------------
module wsh_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wsh_pkg::cmd_t      cmd_i,
  output wsh_pkg::sts_t      sts_o,
  input  wsh_pkg::in_item_t  item_i,
  input  logic               cfg_valid_i,
  input  logic [23:0]        cfg_data_i,
  output wsh_pkg::out_item_t res_o
);
  import wsh_pkg::*;

  localparam int unsigned NumW = DistW + QuoW;

  logic [CountWidth-1:0] mem_q [Depth];
  logic [CountWidth-1:0] rd_q;
  logic [AddrW-1:0]      clr_q;
  logic [DistW-1:0]      max_q;
  in_item_t              it_q;
  logic [QuoW-1:0]       num_q;
  logic [DistW:0]        rem_q;
  logic [QuoW-1:0]       quo_q;
  logic [3:0]            cnt_q;
  logic                  clamp_q;
  logic [2:0]            cat_q;
  logic [9:0]            bin_q;
  logic [AddrW-1:0]      addr_q;
  logic                  valid_q;
  logic [23:0]           add_q;
  logic [CountWidth-1:0] new_q;
  logic                  sat_q;

  logic [NumW-1:0]       prod;
  logic [DistW:0]        rem_sh;
  logic [CountWidth:0]   sum;
  logic [2:0]            cat_d;
  logic [9:0]            bin_d;
  logic                  valid_d;

  localparam logic [CountWidth-1:0] CntMax = '1;

  // quotient is below 2^QuoW, so the upper product bits seed the remainder
  assign prod   = NumW'(item_i.distance) * NumW'(Bins);
  assign rem_sh = {rem_q[DistW-1:0], num_q[QuoW-1]};
  assign sts_o.div_done = (cnt_q == 4'd0);
  assign sts_o.clr_done = (clr_q == AddrW'(Depth - 1));
  assign sts_o.is_acc   = (it_q.kind == KindAcc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxDistReset;
      clr_q <= '0;
    end else begin
      if (cfg_valid_i) max_q <= cfg_data_i;
      if (cmd_i.clr_step && !sts_o.clr_done) clr_q <= clr_q + 1'b1;
    end
  end

  always_comb begin
    if (it_q.kind == KindAcc) begin
      if (it_q.same_identity) cat_d = it_q.row_is_male ? CatGenM : CatGenF;
      else if (it_q.row_is_male && it_q.col_is_male) cat_d = CatImpM;
      else if (!it_q.row_is_male && !it_q.col_is_male) cat_d = CatImpF;
      else cat_d = CatCross;
      bin_d   = clamp_q ? QuoW'(Bins) : quo_q;
      valid_d = 1'b1;
    end else begin
      cat_d   = it_q.read_category;
      bin_d   = it_q.read_bin;
      valid_d = (it_q.read_category < 3'(NumCats)) && (it_q.read_bin <= 10'(Bins));
    end
  end

  assign sum = {1'b0, rd_q} + (CountWidth + 1)'(add_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q    <= item_i;
      num_q   <= prod[QuoW-1:0];
      rem_q   <= {1'b0, prod[NumW-1:QuoW]};
      quo_q   <= '0;
      cnt_q   <= 4'(QuoW);
      clamp_q <= item_i.distance >= max_q;
    end
    if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      cnt_q <= cnt_q - 1'b1;
      if (rem_sh >= {1'b0, max_q}) begin
        rem_q <= rem_sh - {1'b0, max_q};
        quo_q <= {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[QuoW-2:0], 1'b0};
      end
    end
    if (cmd_i.make_addr) begin
      cat_q   <= cat_d;
      bin_q   <= bin_d;
      valid_q <= valid_d;
      addr_q  <= AddrW'(cat_d * 13'(RowLen) + 13'(bin_d));
      add_q   <= it_q.same_identity ? 24'(it_q.row_weight) : it_q.row_weight * it_q.col_weight;
    end
    if (cmd_i.mem_read) rd_q <= mem_q[addr_q];
    if (cmd_i.update) begin
      if (it_q.kind == KindAcc) begin
        new_q <= sum[CountWidth] ? CntMax : sum[CountWidth-1:0];
        sat_q <= sum[CountWidth] || (sum[CountWidth-1:0] == CntMax);
      end else begin
        new_q <= valid_q ? rd_q : '0;
        sat_q <= valid_q && (rd_q == CntMax);
      end
    end
    if (cmd_i.clr_step) mem_q[clr_q] <= '0;
    else if (cmd_i.mem_write && valid_q) begin
      if (it_q.kind == KindAcc) mem_q[addr_q] <= new_q;
      else if (it_q.kind == KindReadClr) mem_q[addr_q] <= '0;
    end
  end

  assign res_o.category  = cat_q;
  assign res_o.bin       = bin_q;
  assign res_o.bin_count = new_q;
  assign res_o.saturated = sat_q;

endmodule

/* hdl/wsh_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsh_ctrl: sequencing controller
// Clears the store after reset, then steps each item through the datapath.
// ----------------------------------------------------------------------------
module wsh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  wsh_pkg::sts_t sts_i,
  output wsh_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);
  import wsh_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StClear;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear:  if (sts_i.clr_done) state_d = StIdle;
      StIdle:   if (start_i) state_d = StDivide;
      StDivide: if (!sts_i.is_acc || sts_i.div_done) state_d = StAddr;
      StAddr:   state_d = StRead;
      StRead:   state_d = StData;
      StData:   state_d = StWrite;
      StWrite:  state_d = StDone;
      StDone:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      StClear:  cmd_o.clr_step = 1'b1;
      StIdle: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      StDivide: cmd_o.div_step = sts_i.is_acc && !sts_i.div_done;
      StAddr:   cmd_o.make_addr = 1'b1;
      StRead:   cmd_o.mem_read = 1'b1;
      StData:   cmd_o.update = 1'b1;
      StWrite:  cmd_o.mem_write = 1'b1;
      StDone:   done_o = 1'b1;
      default:  busy_o = 1'b1;
    endcase
  end

endmodule
